/* hw/rtl/mesh_face_assembler_top_assert.svh */
// ----------------------------------------------------------------------------
// mesh face assembler assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MESH_FACE_ASSEMBLER_TOP_ASSERT_SVH
`define MESH_FACE_ASSEMBLER_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MFA_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define MFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mfa_pkg.sv */
// ----------------------------------------------------------------------------
// mfa_pkg
// shared types and codes of the mesh face assembler
// ----------------------------------------------------------------------------
package mfa_pkg;

    localparam int VERT_DEPTH_DEF = 4096;
    localparam int FACE_MAX_DEF   = 16;

    // command kinds
    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_CORNER   = 2'd1;
    localparam logic [1:0] KIND_NEW_MESH = 2'd2;

    // primitive kinds
    localparam logic PRIM_TRI  = 1'b0;
    localparam logic PRIM_QUAD = 1'b1;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } coord_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        coord_x;
        logic [31:0]        coord_y;
        logic [31:0]        coord_z;
        logic signed [31:0] face_index;
        logic               face_end;
    } in_word_t;

    typedef struct packed {
        logic        prim_kind;
        logic [1:0]  corner;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic        last_of_face;
    } out_word_t;

    // queue and back end status seen by the front end
    typedef struct packed {
        logic q_full;
        logic q_empty;
        logic back_active;
    } drain_status_t;

endpackage

/* hw/rtl/mfa_front.sv */
// ----------------------------------------------------------------------------
// mfa_front
// accepts words, writes vertices, resolves corner indices, builds face jobs
// ----------------------------------------------------------------------------
module mfa_front #(
    parameter int VERT_DEPTH = mfa_pkg::VERT_DEPTH_DEF,
    parameter int FACE_MAX   = mfa_pkg::FACE_MAX_DEF,
    localparam int AW = $clog2(VERT_DEPTH),
    localparam int CW = $clog2(VERT_DEPTH + 1),
    localparam int TW = $clog2(FACE_MAX),
    localparam int LW = $clog2(FACE_MAX + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mfa_pkg::in_word_t               cmd,
    input  mfa_pkg::drain_status_t          status,
    output logic                            vert_we,
    output logic [AW-1:0]                   vert_addr,
    output mfa_pkg::coord_t                 vert_data,
    output logic                            job_push,
    output logic [FACE_MAX-1:0][AW-1:0]     job_corners,
    output logic [FACE_MAX-1:0]             job_valid,
    output logic [LW-1:0]                   job_len
);
    import mfa_pkg::*;

    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] len_reg, len_next;
    logic          hazard_reg, hazard_next;
    logic [AW-1:0] corner_reg [FACE_MAX];
    logic [FACE_MAX-1:0] valid_reg;

    logic          accept;
    logic          back_pending;
    logic          is_corner;
    logic          room;
    logic [32:0]   cnt_ext;
    logic [32:0]   idx_ext;
    logic [32:0]   neg_sum;
    logic [31:0]   pos_zero;
    logic          ok;
    logic [AW-1:0] z;

    assign back_pending = !status.q_empty || status.back_active;
    // after a new mesh, vertex slots may be rewritten: hold off until drained
    assign busy      = status.q_full || (hazard_reg && back_pending);
    assign accept    = start && !busy;
    assign is_corner = accept && (cmd.kind == KIND_CORNER);
    assign room      = len_reg < LW'(FACE_MAX);

    // index resolution against the current vertex count
    always_comb
    begin
        cnt_ext  = 33'(count_reg);
        idx_ext  = {cmd.face_index[31], cmd.face_index};
        neg_sum  = cnt_ext + idx_ext;
        pos_zero = cmd.face_index - 32'sd1;
        if (cmd.face_index[31])
        begin
            ok = !neg_sum[32];
            z  = neg_sum[AW-1:0];
        end
        else
        begin
            ok = (cmd.face_index != 32'sd0) && (idx_ext <= cnt_ext);
            z  = pos_zero[AW-1:0];
        end
    end

    assign vert_we     = accept && (cmd.kind == KIND_VERTEX) && (count_reg < CW'(VERT_DEPTH));
    assign vert_addr   = count_reg[AW-1:0];
    assign vert_data.x = cmd.coord_x;
    assign vert_data.y = cmd.coord_y;
    assign vert_data.z = cmd.coord_z;

    // face snapshot including the closing corner
    assign job_push = is_corner && cmd.face_end;
    assign job_len  = room ? (len_reg + LW'(1)) : len_reg;

    always_comb
    begin
        for (int j = 0; j < FACE_MAX; j++)
        begin
            if (room && (len_reg == LW'(j)))
            begin
                job_corners[j] = z;
                job_valid[j]   = ok;
            end
            else
            begin
                job_corners[j] = corner_reg[j];
                job_valid[j]   = valid_reg[j];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        len_next    = len_reg;
        hazard_next = back_pending ? hazard_reg : 1'b0;
        if (vert_we)
        begin
            count_next = count_reg + CW'(1);
        end
        if (accept && (cmd.kind == KIND_NEW_MESH))
        begin
            count_next  = '0;
            len_next    = '0;
            hazard_next = 1'b1;
        end
        if (is_corner)
        begin
            if (cmd.face_end)
            begin
                len_next = '0;
            end
            else if (room)
            begin
                len_next = len_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            len_reg    <= '0;
            hazard_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            len_reg    <= len_next;
            hazard_reg <= hazard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_corner && room)
        begin
            corner_reg[len_reg[TW-1:0]] <= z;
            valid_reg[len_reg[TW-1:0]]  <= ok;
        end
    end

endmodule

/* hw/rtl/mfa_fifo.sv */
// ----------------------------------------------------------------------------
// mfa_fifo
// two-entry job queue between front and back end
// ----------------------------------------------------------------------------
module mfa_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);
    import mfa_pkg::*;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* hw/rtl/mfa_back.sv */
// ----------------------------------------------------------------------------
// mfa_back
// vertex memory and corner sequencer, one corner word per cycle but for skipped fan triangles and job pops
// ----------------------------------------------------------------------------
module mfa_back #(
    parameter int VERT_DEPTH = mfa_pkg::VERT_DEPTH_DEF,
    parameter int FACE_MAX   = mfa_pkg::FACE_MAX_DEF,
    localparam int AW = $clog2(VERT_DEPTH),
    localparam int TW = $clog2(FACE_MAX),
    localparam int LW = $clog2(FACE_MAX + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        split_quads,
    input  logic                        vert_we,
    input  logic [AW-1:0]               vert_addr,
    input  mfa_pkg::coord_t             vert_data,
    input  logic                        job_avail,
    input  logic [FACE_MAX-1:0][AW-1:0] job_corners,
    input  logic [FACE_MAX-1:0]         job_valid,
    input  logic [LW-1:0]               job_len,
    output logic                        pop,
    output logic                        active,
    output logic                        result_valid,
    output mfa_pkg::out_word_t          result
);
    import mfa_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;
    typedef enum logic [1:0] {MODE_TRI, MODE_QUAD, MODE_SPLIT, MODE_FAN} mode_t;

    state_t        state_reg, state_next;
    mode_t         mode_reg, mode_next, head_mode;
    logic [2:0]    step_reg, step_next;
    logic [TW-1:0] tri_reg, tri_next;
    logic          strobe_reg, strobe_next;

    logic [AW-1:0]       fcorner_reg [FACE_MAX];
    logic [FACE_MAX-1:0] pair_reg;
    logic [TW-1:0]       last_tri_reg;
    coord_t              mem [VERT_DEPTH];
    coord_t              rd_data_reg;
    logic                pk_reg;
    logic [1:0]          pos_reg;
    logic                last_reg;

    // head decode
    logic [FACE_MAX-1:0] pair;
    logic [TW-1:0]       last_tri;
    logic                go;

    // per-cycle corner selection
    logic [TW-1:0] sel;
    logic [1:0]    pos;
    logic          pk;
    logic          last;
    logic          emit;
    logic          rd_en;
    logic [TW-1:0] tri_inc;

    always_comb
    begin
        pair     = '0;
        last_tri = '0;
        for (int i = 1; i < FACE_MAX - 1; i++)
        begin
            pair[i] = job_valid[i] && job_valid[i+1] && (LW'(i + 1) < job_len);
        end
        for (int i = 1; i < FACE_MAX - 1; i++)
        begin
            if (pair[i])
            begin
                last_tri = TW'(i);
            end
        end
        head_mode = MODE_FAN;
        go        = 1'b0;
        if (job_len == LW'(3))
        begin
            head_mode = MODE_TRI;
            go        = &job_valid[2:0];
        end
        else if (job_len == LW'(4))
        begin
            head_mode = split_quads ? MODE_SPLIT : MODE_QUAD;
            go        = &job_valid[3:0];
        end
        else if (job_len > LW'(4))
        begin
            head_mode = MODE_FAN;
            go        = job_valid[0] && (|pair);
        end
    end

    assign tri_inc = tri_reg + TW'(1);

    always_comb
    begin
        sel  = TW'(step_reg);
        pos  = step_reg[1:0];
        pk   = PRIM_TRI;
        last = 1'b0;
        emit = 1'b1;
        case (mode_reg)
            MODE_TRI:
            begin
                last = step_reg == 3'd2;
            end
            MODE_QUAD:
            begin
                pk   = PRIM_QUAD;
                last = step_reg == 3'd3;
            end
            MODE_SPLIT:
            begin
                // triangles (0,1,2) then (0,2,3)
                case (step_reg)
                    3'd3:    sel = TW'(0);
                    3'd4:    sel = TW'(2);
                    3'd5:    sel = TW'(3);
                    default: sel = TW'(step_reg);
                endcase
                pos  = (step_reg >= 3'd3) ? 2'(step_reg - 3'd3) : step_reg[1:0];
                last = step_reg == 3'd5;
            end
            MODE_FAN:
            begin
                // flipped winding (0,i+1,i)
                case (step_reg)
                    3'd0:    sel = TW'(0);
                    3'd1:    sel = tri_inc;
                    default: sel = tri_reg;
                endcase
                emit = pair_reg[tri_reg];
                last = (step_reg == 3'd2) && (tri_reg == last_tri_reg);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign rd_en  = (state_reg == ST_RUN) && emit;
    assign pop    = (state_reg == ST_IDLE) && job_avail;
    assign active = state_reg == ST_RUN;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        step_next   = step_reg;
        tri_next    = tri_reg;
        strobe_next = rd_en;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_avail && go)
                begin
                    state_next = ST_RUN;
                    mode_next  = head_mode;
                    step_next  = 3'd0;
                    tri_next   = (head_mode == MODE_FAN) ? TW'(1) : TW'(0);
                end
            end
            ST_RUN:
            begin
                if (emit && last)
                begin
                    state_next = ST_IDLE;
                end
                else if (mode_reg == MODE_FAN)
                begin
                    if (!emit || (step_reg == 3'd2))
                    begin
                        step_next = 3'd0;
                        tri_next  = tri_inc;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_TRI;
            step_reg   <= 3'd0;
            tri_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            step_reg   <= step_next;
            tri_reg    <= tri_next;
            strobe_reg <= strobe_next;
        end
    end

    // face job payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int j = 0; j < FACE_MAX; j++)
            begin
                fcorner_reg[j] <= job_corners[j];
            end
            pair_reg     <= pair;
            last_tri_reg <= last_tri;
        end
    end

    // vertex memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (vert_we)
        begin
            mem[vert_addr] <= vert_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[fcorner_reg[sel]];
            pk_reg      <= pk;
            pos_reg     <= pos;
            last_reg    <= last;
        end
    end

    assign result_valid        = strobe_reg;
    assign result.prim_kind    = pk_reg;
    assign result.corner       = pos_reg;
    assign result.out_x        = rd_data_reg.x;
    assign result.out_y        = rd_data_reg.y;
    assign result.out_z        = rd_data_reg.z;
    assign result.last_of_face = last_reg;

endmodule

/* hw/rtl/mesh_face_assembler_top.sv */
// ----------------------------------------------------------------------------
// mesh_face_assembler_top
// obj face assembly: vertex store, corner resolution, fan triangulation
// ----------------------------------------------------------------------------
// vertex and corner words: one per cycle, no stall while busy is low
// face end to first corner word: queue entry, job pop, registered vertex read;
// then one corner word per cycle, but for skipped fan triangles and job pops
// busy rises when the two-entry job queue is full, or after a new mesh until
// queued faces drain; results are strobes and cannot be held off
// reset clears counts, queue and sequencer; vertex memory is left as is
// ----------------------------------------------------------------------------
module mesh_face_assembler_top #(
    parameter int VERT_DEPTH = mfa_pkg::VERT_DEPTH_DEF,
    parameter int FACE_MAX   = mfa_pkg::FACE_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mfa_pkg::in_word_t  cmd,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    output logic               result_valid,
    output mfa_pkg::out_word_t result
);
    import mfa_pkg::*;

    localparam int AW = $clog2(VERT_DEPTH);
    localparam int LW = $clog2(FACE_MAX + 1);
    // queued job: resolved corner indices, valid bits, face length
    localparam int JW = FACE_MAX * AW + FACE_MAX + LW;

    // split_quads register
    logic split_quads_reg;

    // front end to vertex memory
    logic          vert_we;
    logic [AW-1:0] vert_addr;
    coord_t        vert_data;

    // front end to queue
    logic                        job_push;
    logic [FACE_MAX-1:0][AW-1:0] job_corners_in;
    logic [FACE_MAX-1:0]         job_valid_in;
    logic [LW-1:0]               job_len_in;

    // queue to back end
    logic [JW-1:0]               q_dout;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_pop;
    logic [FACE_MAX-1:0][AW-1:0] job_corners_out;
    logic [FACE_MAX-1:0]         job_valid_out;
    logic [LW-1:0]               job_len_out;

    logic          back_active;
    drain_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_quads_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            split_quads_reg <= cfg_wr_data;
        end
    end

    assign status.q_full      = q_full;
    assign status.q_empty     = q_empty;
    assign status.back_active = back_active;

    // front end: accepts words while not busy, writes vertices, collects face corners
    mfa_front #(
        .VERT_DEPTH (VERT_DEPTH),
        .FACE_MAX   (FACE_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .status      (status),
        .vert_we     (vert_we),
        .vert_addr   (vert_addr),
        .vert_data   (vert_data),
        .job_push    (job_push),
        .job_corners (job_corners_in),
        .job_valid   (job_valid_in),
        .job_len     (job_len_in)
    );

    // face jobs wait here while the back end emits an earlier face
    mfa_fifo #(
        .WIDTH (JW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   ({job_corners_in, job_valid_in, job_len_in}),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign job_len_out     = q_dout[LW-1:0];
    assign job_valid_out   = q_dout[LW +: FACE_MAX];
    assign job_corners_out = q_dout[JW-1 -: FACE_MAX * AW];

    // back end: classifies the face and streams corner words
    mfa_back #(
        .VERT_DEPTH (VERT_DEPTH),
        .FACE_MAX   (FACE_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .split_quads  (split_quads_reg),
        .vert_we      (vert_we),
        .vert_addr    (vert_addr),
        .vert_data    (vert_data),
        .job_avail    (!q_empty),
        .job_corners  (job_corners_out),
        .job_valid    (job_valid_out),
        .job_len      (job_len_out),
        .pop          (q_pop),
        .active       (back_active),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* hw/rtl/mfa_checker.sv */
// ----------------------------------------------------------------------------
// mfa_checker
// port-level checks on the corner word stream
// ----------------------------------------------------------------------------
`include "mesh_face_assembler_top_assert.svh"

module mfa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input mfa_pkg::out_word_t result
);
    import mfa_pkg::*;

    logic       quad_word;
    logic       tri_word;
    logic       quad_open;
    logic       tri_open;
    logic       quad_seq;
    logic       quad_end;
    logic [1:0] want_corner_reg;

    assign quad_word = result_valid && (result.prim_kind == PRIM_QUAD);
    assign tri_word  = result_valid && (result.prim_kind == PRIM_TRI);
    assign quad_open = quad_word && (result.corner != 2'd3);
    assign tri_open  = tri_word && (result.corner != 2'd2);
    assign quad_seq  = quad_word && (result.corner == want_corner_reg);
    assign quad_end  = quad_word && result.last_of_face;

    // corner position expected in the next cycle
    always_ff @(posedge clk)
    begin
        want_corner_reg <= result.corner + 2'd1;
    end

    // quad corners come back to back in order
    `MFA_ASSERT_NEXT(a_quad_run, quad_open, quad_seq, "quad corner word out of order")

    // a triangle once started is finished without a gap
    `MFA_ASSERT_NEXT(a_tri_run, tri_open, tri_word, "triangle corner word missing")

    // triangles have three corners
    `MFA_ASSERT_HOLDS(a_tri_range, tri_word, result.corner != 2'd3, "bad triangle corner")

    // a quad ends its face only on its last corner
    `MFA_ASSERT_HOLDS(a_quad_last, quad_end, result.corner == 2'd3, "quad face ended early")

endmodule

bind mesh_face_assembler_top mfa_checker u_mfa_checker (.*);
